>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the ray/triangle intersection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ray_triangle_intersection: implication check failed");

// Implication whose consequence is checked at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ray_triangle_intersection: next-cycle check failed");

`endif

>>> rtl/core/rti_pkg.sv
// Shared constants and types of the ray/triangle intersection block.
package rti_pkg;

  // Width of the result distance and its saturation value.
  localparam int unsigned DistWidth = 31;
  localparam logic [DistWidth-1:0] DistMax = '1;

  // Width of the epsilon register.
  localparam int unsigned EpsWidth = 16;

  // Configuration register index width and register map.
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_EPSILON  = 3'd6
  } cfg_reg_e;

  typedef logic [DistWidth-1:0] dist_t;

endpackage

>>> rtl/core/rti_if.sv
// Valid/ready channel interfaces for triangle words and result words.
interface rti_tri_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex0_x;
  logic signed [COORD_WIDTH-1:0] vertex0_y;
  logic signed [COORD_WIDTH-1:0] vertex0_z;
  logic signed [COORD_WIDTH-1:0] vertex1_x;
  logic signed [COORD_WIDTH-1:0] vertex1_y;
  logic signed [COORD_WIDTH-1:0] vertex1_z;
  logic signed [COORD_WIDTH-1:0] vertex2_x;
  logic signed [COORD_WIDTH-1:0] vertex2_y;
  logic signed [COORD_WIDTH-1:0] vertex2_z;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z,
    output ready
  );
endinterface

interface rti_res_if;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  rti_pkg::dist_t        distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

>>> rtl/core/rti_mul.sv
// Two-stage signed multiplier: B is split in halves, partial products are registered, then summed.
module rti_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 33
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [WA-1:0]     a_i,
  input  logic signed [WB-1:0]     b_i,
  output logic signed [WA+WB-1:0]  p_o
);

  localparam int unsigned Lo = WB / 2;
  localparam int unsigned Hi = WB - Lo;
  localparam int unsigned Pw = WA + WB;

  logic signed [WA+Lo:0]   plo_d, plo_q;
  logic signed [WA+Hi-1:0] phi_d, phi_q;
  logic signed [Pw-1:0]    p_q;

  // The low half of B is unsigned, the high half carries the sign.
  assign plo_d = a_i * $signed({1'b0, b_i[Lo-1:0]});
  assign phi_d = a_i * $signed(b_i[WB-1:Lo]);

  // Partial products register, then the aligned sum registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      p_q   <= (Pw'(phi_q) <<< Lo) + Pw'(plo_q);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/ray_triangle_intersection.sv
// Ray/triangle intersection pipeline (Moller-Trumbore, exact fixed point).
//
// Usage: the ray origin, direction and epsilon are written through the
// configuration port while the block is idle. Triangle words arrive on tri_i
// (valid/ready); each accepted word yields exactly one result word on res_o
// carrying hit and the truncated, saturated distance t (zero on a miss).
// The path is 41 register stages, the first of which captures the word at the
// accepting edge: nine arithmetic stages (edges, two multiplier rows, cross
// differences, sums, sign fix, tests), one stage per quotient bit of the 31-bit
// restoring divider, and the output register. Throughput is one triangle word
// per cycle while the result word is not stalled.
// The whole pipeline advances on one enable: when the result register holds
// a word that the receiver does not take, every stage holds and tri_i.ready
// drops; nothing is lost or repeated. Reset clears all valid bits and sets
// the ray to origin zero, direction +z (1.0) and epsilon to one step.
// Distances are in the coordinate format with FRAC_BITS fraction bits.
module ray_triangle_intersection #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rti_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]              cfg_data_i,
  rti_tri_if.sink                             tri_i,
  rti_res_if.source                           res_o
);

`include "assert_macros.svh"

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned Ew   = W + 1;
  localparam int unsigned Pw   = 2 * W + 2;
  localparam int unsigned Qw   = 2 * W + 3;
  localparam int unsigned Sw   = 3 * W + 6;
  localparam int unsigned Dw   = rti_pkg::DistWidth;
  localparam int unsigned Ew16 = rti_pkg::EpsWidth;
  localparam int unsigned Sh   = Dw - FRAC_BITS;
  localparam int unsigned NPre = 9;
  localparam int unsigned NDiv = Dw;
  localparam int unsigned Lat  = NPre + NDiv + 1;
  localparam logic [W-1:0] DirZReset = W'(1) << FRAC_BITS;

  // Ray configuration registers.
  logic signed [W-1:0] org_q [3];
  logic signed [W-1:0] dir_q [3];
  logic [Ew16-1:0]     eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= DirZReset;
      eps_q    <= Ew16'(1);
    end else if (cfg_we_i) begin
      case (rti_pkg::cfg_reg_e'(cfg_idx_i))
        rti_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rti_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        rti_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        rti_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        rti_pkg::CFG_EPSILON:  eps_q    <= cfg_data_i[Ew16-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages move together unless the result word stalls.
  logic [Lat-1:0] vld_q;
  logic           en;

  assign en          = !vld_q[Lat-1] || res_o.ready;
  assign tri_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], tri_i.valid};
    end
  end

  // Stage 1: edges and origin offset.
  logic signed [W-1:0]  v0 [3];
  logic signed [W-1:0]  v1 [3];
  logic signed [W-1:0]  v2 [3];
  logic signed [Ew-1:0] e1_q [4][3];
  logic signed [Ew-1:0] e2_q [4][3];
  logic signed [Ew-1:0] s_q  [4][3];

  assign v0[0] = tri_i.vertex0_x;
  assign v0[1] = tri_i.vertex0_y;
  assign v0[2] = tri_i.vertex0_z;
  assign v1[0] = tri_i.vertex1_x;
  assign v1[1] = tri_i.vertex1_y;
  assign v1[2] = tri_i.vertex1_z;
  assign v2[0] = tri_i.vertex2_x;
  assign v2[1] = tri_i.vertex2_y;
  assign v2[2] = tri_i.vertex2_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[0][i] <= Ew'(v1[i]) - Ew'(v0[i]);
        e2_q[0][i] <= Ew'(v2[i]) - Ew'(v0[i]);
        s_q[0][i]  <= Ew'(org_q[i]) - Ew'(v0[i]);
      end
      for (int k = 1; k < 4; k++) begin
        e1_q[k] <= e1_q[k-1];
        e2_q[k] <= e2_q[k-1];
        s_q[k]  <= s_q[k-1];
      end
    end
  end

  // Stages 2-3: cross product terms of P = dir x e2 and Q = s x e1.
  logic signed [2*W:0]   pa [3];
  logic signed [2*W:0]   pb [3];
  logic signed [2*W+1:0] qa [3];
  logic signed [2*W+1:0] qb [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.WA(W), .WB(Ew)) u_pa (
      .clk_i(clk_i), .en_i(en), .a_i(dir_q[J]), .b_i(e2_q[0][K]), .p_o(pa[i]));
    rti_mul #(.WA(W), .WB(Ew)) u_pb (
      .clk_i(clk_i), .en_i(en), .a_i(dir_q[K]), .b_i(e2_q[0][J]), .p_o(pb[i]));
    rti_mul #(.WA(Ew), .WB(Ew)) u_qa (
      .clk_i(clk_i), .en_i(en), .a_i(s_q[0][J]), .b_i(e1_q[0][K]), .p_o(qa[i]));
    rti_mul #(.WA(Ew), .WB(Ew)) u_qb (
      .clk_i(clk_i), .en_i(en), .a_i(s_q[0][K]), .b_i(e1_q[0][J]), .p_o(qb[i]));
  end

  // Stage 4: cross product differences.
  logic signed [Pw-1:0] p_q [3];
  logic signed [Qw-1:0] q_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= Pw'(pa[i]) - Pw'(pb[i]);
        q_q[i] <= Qw'(qa[i]) - Qw'(qb[i]);
      end
    end
  end

  // Stages 5-6: dot product terms for det, u, v and t numerators.
  logic signed [3*W+2:0] det_t [3];
  logic signed [3*W+2:0] un_t  [3];
  logic signed [3*W+2:0] vn_t  [3];
  logic signed [3*W+3:0] tn_t  [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.WA(Ew), .WB(Pw)) u_det (
      .clk_i(clk_i), .en_i(en), .a_i(e1_q[3][i]), .b_i(p_q[i]), .p_o(det_t[i]));
    rti_mul #(.WA(Ew), .WB(Pw)) u_un (
      .clk_i(clk_i), .en_i(en), .a_i(s_q[3][i]), .b_i(p_q[i]), .p_o(un_t[i]));
    rti_mul #(.WA(W), .WB(Qw)) u_vn (
      .clk_i(clk_i), .en_i(en), .a_i(dir_q[i]), .b_i(q_q[i]), .p_o(vn_t[i]));
    rti_mul #(.WA(Ew), .WB(Qw)) u_tn (
      .clk_i(clk_i), .en_i(en), .a_i(e2_q[3][i]), .b_i(q_q[i]), .p_o(tn_t[i]));
  end

  // Stage 7: sums of the dot product terms.
  logic signed [Sw-1:0] det_q, un_q, vn_q, tn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= Sw'(det_t[0]) + Sw'(det_t[1]) + Sw'(det_t[2]);
      un_q  <= Sw'(un_t[0]) + Sw'(un_t[1]) + Sw'(un_t[2]);
      vn_q  <= Sw'(vn_t[0]) + Sw'(vn_t[1]) + Sw'(vn_t[2]);
      tn_q  <= Sw'(tn_t[0]) + Sw'(tn_t[1]) + Sw'(tn_t[2]);
    end
  end

  // Stage 8: flip all numerators so that det is not negative.
  logic signed [Sw-1:0] det_a_q, un_a_q, vn_a_q, tn_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (det_q[Sw-1]) begin
        det_a_q <= -det_q;
        un_a_q  <= -un_q;
        vn_a_q  <= -vn_q;
        tn_a_q  <= -tn_q;
      end else begin
        det_a_q <= det_q;
        un_a_q  <= un_q;
        vn_a_q  <= vn_q;
        tn_a_q  <= tn_q;
      end
    end
  end

  // Stage 9: inside tests, saturation check and divider setup.
  logic signed [Sw-1:0] lim;
  logic signed [Sw:0]   uv_sum;
  logic signed [Sw-1:0] tn_sh;
  logic signed [Sw-1:0] r_init;
  logic                 miss_d;
  logic                 sat_d;

  assign lim    = $signed(Sw'(eps_q) << (2 * FRAC_BITS));
  assign uv_sum = (Sw+1)'(un_a_q) + (Sw+1)'(vn_a_q);
  assign tn_sh  = tn_a_q <<< FRAC_BITS;
  assign r_init = tn_a_q >>> Sh;
  assign sat_d  = r_init >= det_a_q;
  assign miss_d = (det_a_q == '0) || (det_a_q < lim)
               || un_a_q[Sw-1] || (un_a_q > det_a_q)
               || vn_a_q[Sw-1] || (uv_sum > (Sw+1)'(det_a_q))
               || tn_a_q[Sw-1];

  // Divider stages: one quotient bit of (tn << FRAC_BITS) / det per stage.
  logic [Sw-1:0] r_q    [NDiv+1];
  logic [Sw-1:0] d_q    [NDiv+1];
  logic [Dw-1:0] lo_q   [NDiv+1];
  logic [Dw-1:0] quo_q  [NDiv+1];
  logic          miss_q [NDiv+1];
  logic          sat_q  [NDiv+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]    <= r_init;
      d_q[0]    <= det_a_q;
      lo_q[0]   <= tn_sh[Dw-1:0];
      quo_q[0]  <= '0;
      miss_q[0] <= miss_d;
      sat_q[0]  <= sat_d;
    end
  end

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [Sw-1:0] r2;
    logic          ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign r2 = {r_q[k][Sw-2:0], lo_q[k][Dw-1]};
    assign ge = r2 >= d_q[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[k+1]    <= ge ? r2 - d_q[k] : r2;
        d_q[k+1]    <= d_q[k];
        lo_q[k+1]   <= lo_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][Dw-2:0], ge};
        miss_q[k+1] <= miss_q[k];
        sat_q[k+1]  <= sat_q[k];
      end
    end
  end

  // Output register: saturate, apply the distance threshold, clear misses.
  rti_pkg::dist_t dist_sel;
  rti_pkg::dist_t eps_ext;
  logic           hit_d;
  logic           hit_q;
  rti_pkg::dist_t dist_q;

  assign eps_ext  = Dw'(eps_q);
  assign dist_sel = sat_q[NDiv] ? rti_pkg::DistMax : quo_q[NDiv];
  assign hit_d    = !miss_q[NDiv] && (dist_sel > eps_ext);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= hit_d ? dist_sel : '0;
    end
  end

  assign res_o.valid    = vld_q[Lat-1];
  assign res_o.hit      = hit_q;
  assign res_o.distance = dist_q;

  // Checks on the result word, the stall behavior and the sign fix.
  `ASSERT_IMPLY(a_hit_beyond_eps, res_o.valid && res_o.hit, res_o.distance > eps_ext)
  `ASSERT_IMPLY(a_miss_zero_dist, res_o.valid && !res_o.hit, res_o.distance == '0)
  `ASSERT_NEXT(a_stall_holds_pipe, vld_q[Lat-1] && !res_o.ready, $stable(vld_q))
  `ASSERT_IMPLY(a_det_not_negative, vld_q[NPre-2], !det_a_q[Sw-1])

endmodule

>>> verif/ray_triangle_intersection_tb.sv
// Self-checking testbench for the ray/triangle intersection pipeline.
module ray_triangle_intersection_tb;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [127:0] wide_t;
  typedef struct packed {coord_t x, y, z;} vec_t;
  typedef struct packed {vec_t v0, v1, v2;} tri_t;
  typedef struct packed {logic hit; rti_pkg::dist_t distance;} hit_t;

  localparam logic [rti_pkg::CfgIdxWidth-1:0] CfgUnused = 3'd7;
  localparam int unsigned Latency = 41;
  localparam coord_t One = 32'sh0001_0000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [rti_pkg::CfgIdxWidth-1:0] cfg_idx;
  logic [31:0] cfg_data;

  rti_tri_if #(.COORD_WIDTH(32)) tri_bus ();
  rti_res_if res_bus ();

  ray_triangle_intersection dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .tri_i     (tri_bus),
    .res_o     (res_bus)
  );

  // Ray held by the testbench, kept in step with the block's registers.
  vec_t ray_org, ray_dir;
  logic [15:0] ray_eps;

  hit_t expected_hits[$];
  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_req = 0;
  int hold_left = 0;

  always #5 clk_i = ~clk_i;

  // Run limit.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1,
                                 wide_t b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  // Exact Moller-Trumbore test at full precision against the current ray.
  function automatic hit_t predict_hit(tri_t t);
    wide_t e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz, dx, dy, dz;
    wide_t px, py, pz, qx, qy, qz, det, un, vn, tn, lim;
    logic [127:0] quo;
    rti_pkg::dist_t dist_val;
    hit_t r;
    r = '0;
    e1x = wide_t'(t.v1.x) - wide_t'(t.v0.x);
    e1y = wide_t'(t.v1.y) - wide_t'(t.v0.y);
    e1z = wide_t'(t.v1.z) - wide_t'(t.v0.z);
    e2x = wide_t'(t.v2.x) - wide_t'(t.v0.x);
    e2y = wide_t'(t.v2.y) - wide_t'(t.v0.y);
    e2z = wide_t'(t.v2.z) - wide_t'(t.v0.z);
    sx = wide_t'(ray_org.x) - wide_t'(t.v0.x);
    sy = wide_t'(ray_org.y) - wide_t'(t.v0.y);
    sz = wide_t'(ray_org.z) - wide_t'(t.v0.z);
    dx = wide_t'(ray_dir.x);
    dy = wide_t'(ray_dir.y);
    dz = wide_t'(ray_dir.z);
    px = dy * e2z - dz * e2y;
    py = dz * e2x - dx * e2z;
    pz = dx * e2y - dy * e2x;
    qx = sy * e1z - sz * e1y;
    qy = sz * e1x - sx * e1z;
    qz = sx * e1y - sy * e1x;
    det = dot3(e1x, e1y, e1z, px, py, pz);
    un = dot3(sx, sy, sz, px, py, pz);
    vn = dot3(dx, dy, dz, qx, qy, qz);
    tn = dot3(e2x, e2y, e2z, qx, qy, qz);
    // Flip signs so that the determinant is not negative.
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    lim = wide_t'({96'd0, ray_eps, 16'd0}) <<< 16;
    if (det == 0 || det < lim) return r;
    if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0) return r;
    quo = $unsigned(tn <<< 16) / $unsigned(det);
    dist_val = (quo > 128'(rti_pkg::DistMax)) ? rti_pkg::DistMax
                                               : quo[rti_pkg::DistWidth-1:0];
    if ({1'b0, dist_val} <= 32'(ray_eps)) return r;
    r.hit = 1'b1;
    r.distance = dist_val;
    return r;
  endfunction

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else if (stall_on) begin
      res_bus.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_hits.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = expected_hits.pop_front();
        if (res_bus.hit !== want.hit)
          report($sformatf("hit %b, expected %b", res_bus.hit, want.hit));
        if (res_bus.distance !== want.distance)
          report($sformatf("distance %h, expected %h", res_bus.distance, want.distance));
      end
    end
  end

  // Send one triangle word and record its expected result on acceptance.
  task automatic send_tri(tri_t t);
    hit_t r;
    r = predict_hit(t);
    tri_bus.valid <= 1'b1;
    tri_bus.vertex0_x <= t.v0.x;
    tri_bus.vertex0_y <= t.v0.y;
    tri_bus.vertex0_z <= t.v0.z;
    tri_bus.vertex1_x <= t.v1.x;
    tri_bus.vertex1_y <= t.v1.y;
    tri_bus.vertex1_z <= t.v1.z;
    tri_bus.vertex2_x <= t.v2.x;
    tri_bus.vertex2_y <= t.v2.y;
    tri_bus.vertex2_z <= t.v2.z;
    do @(posedge clk_i); while (!tri_bus.ready);
    expected_hits.insert(expected_hits.size(), r);
  endtask

  task automatic tri_idle(int n);
    tri_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender with bursts and gaps.
  task automatic send_paced(tri_t t);
    if (burst_left == 0) begin
      if (gaps_on) tri_idle($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_tri(t);
  endtask

  // Wait until every expected result has arrived, then let the pipeline empty.
  task automatic drain();
    tri_idle(1);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [rti_pkg::CfgIdxWidth-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Load a whole ray; a write to the unused index must change nothing.
  task automatic set_ray(vec_t o, vec_t d, logic [15:0] e);
    cfg_write(rti_pkg::CFG_ORIGIN_X, o.x);
    cfg_write(rti_pkg::CFG_ORIGIN_Y, o.y);
    cfg_write(rti_pkg::CFG_ORIGIN_Z, o.z);
    cfg_write(rti_pkg::CFG_DIR_X, d.x);
    cfg_write(rti_pkg::CFG_DIR_Y, d.y);
    cfg_write(rti_pkg::CFG_DIR_Z, d.z);
    cfg_write(rti_pkg::CFG_EPSILON, {16'(~e), e});
    cfg_write(CfgUnused, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    ray_org = o;
    ray_dir = d;
    ray_eps = e;
  endtask

  function automatic coord_t rand_span(int bits);
    return coord_t'($urandom_range(0, (1 << (bits + 1)) - 1)) - (coord_t'(1) <<< bits);
  endfunction

  function automatic vec_t rand_vec(int bits);
    vec_t v;
    v.x = rand_span(bits); v.y = rand_span(bits); v.z = rand_span(bits);
    return v;
  endfunction

  function automatic vec_t vadd(vec_t a, vec_t b);
    vec_t v;
    v.x = a.x + b.x; v.y = a.y + b.y; v.z = a.z + b.z;
    return v;
  endfunction

  // Mostly triangles built around a point on the ray, the rest noise.
  function automatic tri_t rand_tri();
    tri_t t;
    vec_t p, a, b;
    int kind, k, sc;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    end else if (kind == 1) begin
      t.v0 = rand_vec(20); t.v1 = rand_vec(20); t.v2 = rand_vec(20);
    end else begin
      k = $urandom_range(0, 12) - 2;
      p.x = ray_org.x + k * ray_dir.x;
      p.y = ray_org.y + k * ray_dir.y;
      p.z = ray_org.z + k * ray_dir.z;
      sc = $urandom_range(2, 22);
      a = rand_vec(sc);
      b = rand_vec(sc);
      t.v0 = vadd(p, a);
      t.v1 = vadd(p, b);
      t.v2 = vadd(vadd(p, rand_vec(sc > 4 ? sc - 3 : 1)), '{-a.x - b.x, -a.y - b.y, -a.z - b.z});
    end
    return t;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_paced(rand_tri());
  endtask

  function automatic tri_t make_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                                    coord_t bz, coord_t cx, coord_t cy, coord_t cz);
    tri_t t;
    t.v0 = '{ax, ay, az}; t.v1 = '{bx, by, bz}; t.v2 = '{cx, cy, cz};
    return t;
  endfunction

  // Directed cases against the reset ray (origin zero, looking along +z).
  task automatic test_reset_ray();
    coord_t mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    ray_org = '0;
    ray_dir = '{0, 0, One};
    ray_eps = 16'd1;
    // Plain hit at five units, both windings.
    send_tri(make_tri(-One, -One, 5 * One, 2 * One, -One, 5 * One, -One, 2 * One, 5 * One));
    send_tri(make_tri(-One, -One, 5 * One, -One, 2 * One, 5 * One, 2 * One, -One, 5 * One));
    // Triangle behind the origin.
    send_tri(make_tri(-One, -One, -5 * One, 2 * One, -One, -5 * One, -One, 2 * One, -5 * One));
    // Degenerate: all corners equal, and collinear corners.
    send_tri(make_tri(One, One, One, One, One, One, One, One, One));
    send_tri(make_tri(0, 0, One, One, One, 2 * One, 2 * One, 2 * One, 3 * One));
    // Plane parallel to the ray gives a zero determinant.
    send_tri(make_tri(-One, 0, 0, One, 0, One, 0, 0, 2 * One));
    // Ray passes outside the triangle.
    send_tri(make_tri(One, One, One, 3 * One, One, One, One, 3 * One, One));
    // Ray through a corner, along the edge between the first two corners, and on the u = 0 edge.
    send_tri(make_tri(0, 0, 3 * One, One, 0, 3 * One, 0, One, 3 * One));
    send_tri(make_tri(-One, -One, 3 * One, One, One, 3 * One, -One, One, 3 * One));
    send_tri(make_tri(0, -One, 3 * One, One, One, 3 * One, 0, One, 3 * One));
    // Distance at and just beyond epsilon.
    send_tri(make_tri(-One, -One, 1, 2 * One, -One, 1, -One, 2 * One, 1));
    send_tri(make_tri(-One, -One, 2, 2 * One, -One, 2, -One, 2 * One, 2));
    // Very far plane saturates the distance; extremes of every field.
    send_tri(make_tri(mn, mn, mx, mx, mn, mx, mn, mx, mx));
    send_tri(make_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_tri(make_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn));
    send_tri(make_tri(-1, -1, -1, 0, 0, 0, -1, 0, -1));
    send_tri(make_tri(0, 0, 0, mx, 0, 0, 0, mx, 0));
    drain();
  endtask

  // Random phases under several rays, extremes among them.
  task automatic test_random_rays();
    vec_t big, low;
    big = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    low = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    set_ray(rand_vec(20), rand_vec(17), 16'($urandom_range(0, 64)));
    send_random(300);
    drain();
    set_ray(rand_vec(18), '{rand_span(2), rand_span(2), 32'sd1}, 16'd0);
    send_random(250);
    drain();
    set_ray(big, low, 16'hFFFF);
    send_random(200);
    drain();
    set_ray(low, big, 16'd0);
    send_random(200);
    drain();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    set_ray(rand_vec(16), '{0, 0, -One}, 16'($urandom));
    send_random(250);
    drain();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    set_ray('{$urandom, $urandom, $urandom}, '{$urandom, $urandom, $urandom}, 16'($urandom));
    send_random(200);
    drain();
    set_ray(rand_vec(22), rand_vec(19), 16'($urandom_range(0, 16)));
    send_random(200);
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering words.
  task automatic test_backpressure();
    set_ray(rand_vec(16), rand_vec(17), 16'd4);
    gaps_on = 1'b0;
    hold_req = 400;
    send_random(330);
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= rti_pkg::CFG_ORIGIN_X;
    cfg_data <= '0;
    tri_bus.valid <= 1'b0;
    {tri_bus.vertex0_x, tri_bus.vertex0_y, tri_bus.vertex0_z} <= '0;
    {tri_bus.vertex1_x, tri_bus.vertex1_y, tri_bus.vertex1_z} <= '0;
    {tri_bus.vertex2_x, tri_bus.vertex2_y, tri_bus.vertex2_z} <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_ray();
    test_random_rays();
    test_backpressure();

    wait_cycles = 0;
    while (expected_hits.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 8) @(posedge clk_i);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/rti_if.sv
rtl/core/rti_mul.sv
rtl/core/ray_triangle_intersection.sv
verif/ray_triangle_intersection_tb.sv
